@@ hdl/sbp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types, codes and the CRC-32 byte step for the settings blob parser.
// ----------------------------------------------------------------------------
package sbp_pkg;

    // Blob layout limits
    localparam int MAX_BLOB_BYTES = 512;
    localparam int MAX_THRESHOLDS = 8;
    localparam int MAX_IDS        = 8;
    localparam int TEXT_BYTES     = 32;
    localparam int MIN_BLOB_BYTES = 28;

    localparam logic [7:0]  BLOB_VERSION = 8'd1;
    localparam logic [7:0]  FLAGS_RSVD   = 8'hF8;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    localparam logic [7:0] MAGIC_0 = 8'h41;  // 'A'
    localparam logic [7:0] MAGIC_1 = 8'h4D;  // 'M'
    localparam logic [7:0] MAGIC_2 = 8'h53;  // 'S'
    localparam logic [7:0] MAGIC_3 = 8'h54;  // 'T'

    // Field codes
    localparam logic [3:0] FC_REVISION   = 4'd0;
    localparam logic [3:0] FC_FLAGS      = 4'd1;
    localparam logic [3:0] FC_ROTATION   = 4'd2;
    localparam logic [3:0] FC_BRIGHTNESS = 4'd3;
    localparam logic [3:0] FC_DIM        = 4'd4;
    localparam logic [3:0] FC_OFF        = 4'd5;
    localparam logic [3:0] FC_THR_COUNT  = 4'd6;
    localparam logic [3:0] FC_THRESHOLD  = 4'd7;
    localparam logic [3:0] FC_HID_COUNT  = 4'd8;
    localparam logic [3:0] FC_ORD_COUNT  = 4'd11;
    localparam logic [3:0] FC_LEN_OFS    = 4'd1;
    localparam logic [3:0] FC_CHAR_OFS   = 4'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
    localparam logic [2:0] ST_MALFORMED   = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_BAD_CRC     = 3'd4;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic        is_status;
        logic [3:0]  field_code;
        logic [2:0]  entry_index;
        logic [4:0]  char_index;
        logic [31:0] field_value;
        logic [2:0]  status;
        logic        run_last;
    } t_result;

    // Up to two results per input beat: field first, then status
    typedef struct packed {
        logic    field_valid;
        logic    status_valid;
        t_result field;
        t_result stat;
    } t_push;

    function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic t_result make_field(logic [3:0] code, logic [7:0] entry,
                                           logic [4:0] chr, logic [31:0] value);
        t_result r;
        r.is_status   = 1'b0;
        r.field_code  = code;
        r.entry_index = entry[2:0];
        r.char_index  = chr;
        r.field_value = value;
        r.status      = ST_OK;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/sbp_in_if.sv @@
// ----------------------------------------------------------------------------
// sbp_in_if
// Input channel: one blob byte per beat with a last flag.
// ----------------------------------------------------------------------------
interface sbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/sbp_out_if.sv @@
// ----------------------------------------------------------------------------
// sbp_out_if
// Output channel: one decoded field or final status per beat.
// ----------------------------------------------------------------------------
interface sbp_out_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [3:0]  field_code;
    logic [2:0]  entry_index;
    logic [4:0]  char_index;
    logic [31:0] field_value;
    logic [2:0]  status;
    logic        run_last;

    modport source (output valid, output is_status, output field_code, output entry_index,
                    output char_index, output field_value, output status,
                    output run_last, input ready);
    modport sink   (input valid, input is_status, input field_code, input entry_index,
                    input char_index, input field_value, input status,
                    input run_last, output ready);
endinterface

@@ hdl/sbp_core.sv @@
// ----------------------------------------------------------------------------
// sbp_core
// Per-byte step: tail delay line, CRC-32 and field parser, final status.
// ----------------------------------------------------------------------------
module sbp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output sbp_pkg::t_push o_push
);
    import sbp_pkg::*;

    typedef enum logic [19:0] {
        PH_MAGIC0   = 20'h00001,
        PH_MAGIC1   = 20'h00002,
        PH_MAGIC2   = 20'h00004,
        PH_MAGIC3   = 20'h00008,
        PH_VERSION  = 20'h00010,
        PH_REV      = 20'h00020,
        PH_FLAGS    = 20'h00040,
        PH_ROT      = 20'h00080,
        PH_BRIGHT   = 20'h00100,
        PH_DIM      = 20'h00200,
        PH_OFF      = 20'h00400,
        PH_THRCOUNT = 20'h00800,
        PH_THR      = 20'h01000,
        PH_HIDCOUNT = 20'h02000,
        PH_HIDLEN   = 20'h04000,
        PH_HIDCHAR  = 20'h08000,
        PH_ORDCOUNT = 20'h10000,
        PH_ORDLEN   = 20'h20000,
        PH_ORDCHAR  = 20'h40000,
        PH_DONE     = 20'h80000
    } t_phase;

    logic [7:0]  r_tail [4];
    logic [7:0]  n_tail [4];
    logic [9:0]  r_byte_count, n_byte_count;
    logic [31:0] r_crc, n_crc;
    logic [1:0]  r_header_bad, n_header_bad;
    t_phase      r_phase, n_phase;
    logic [31:0] r_wacc, n_wacc;
    logic [1:0]  r_widx, n_widx;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_index, n_index;
    logic [7:0]  r_chars_left, n_chars_left;
    logic [4:0]  r_char_pos, n_char_pos;
    logic        r_struct_err, n_struct_err;

    always_comb begin
        logic [7:0]  leaving;
        logic        content;
        logic [31:0] acc_new;
        logic [7:0]  idx_inc;
        logic [7:0]  cl_dec;
        logic [1:0]  hb;
        logic [31:0] stored;
        logic        ord;
        logic [3:0]  base;
        t_phase      after;
        logic        f_valid;
        t_result     f;
        logic [2:0]  st;

        for (int k = 0; k < 4; k++) begin
            n_tail[k] = r_tail[k];
        end
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_header_bad = r_header_bad;
        n_phase      = r_phase;
        n_wacc       = r_wacc;
        n_widx       = r_widx;
        n_total      = r_total;
        n_index      = r_index;
        n_chars_left = r_chars_left;
        n_char_pos   = r_char_pos;
        n_struct_err = r_struct_err;
        f_valid      = 1'b0;
        f            = make_field(FC_REVISION, 8'd0, 5'd0, 32'd0);

        leaving = r_tail[0];
        content = (r_byte_count >= 10'd4);
        acc_new = r_wacc | ({24'd0, leaving} << {r_widx, 3'b000});
        idx_inc = r_index + 8'd1;
        cl_dec  = r_chars_left - 8'd1;
        hb      = r_header_bad;
        ord     = (r_phase == PH_ORDCOUNT) || (r_phase == PH_ORDLEN)
               || (r_phase == PH_ORDCHAR);
        base    = ord ? FC_ORD_COUNT : FC_HID_COUNT;
        after   = ord ? PH_DONE : PH_ORDCOUNT;

        if (content) begin
            n_tail[0] = r_tail[1];
            n_tail[1] = r_tail[2];
            n_tail[2] = r_tail[3];
            n_tail[3] = i_byte;
            n_crc     = crc32_byte(r_crc, leaving);
            if (!r_struct_err) begin
                case (r_phase)
                    PH_MAGIC0: begin
                        if (leaving != MAGIC_0) n_header_bad[0] = 1'b1;
                        n_phase = PH_MAGIC1;
                    end
                    PH_MAGIC1: begin
                        if (leaving != MAGIC_1) n_header_bad[0] = 1'b1;
                        n_phase = PH_MAGIC2;
                    end
                    PH_MAGIC2: begin
                        if (leaving != MAGIC_2) n_header_bad[0] = 1'b1;
                        n_phase = PH_MAGIC3;
                    end
                    PH_MAGIC3: begin
                        if (leaving != MAGIC_3) n_header_bad[0] = 1'b1;
                        n_phase = PH_VERSION;
                    end
                    PH_VERSION: begin
                        if (hb == 2'b00 && leaving != BLOB_VERSION) hb[1] = 1'b1;
                        n_header_bad = hb;
                        if (hb != 2'b00) n_struct_err = 1'b1;
                        n_wacc  = 32'd0;
                        n_widx  = 2'd0;
                        n_phase = PH_REV;
                    end
                    PH_REV, PH_DIM, PH_OFF: begin
                        n_widx = r_widx + 2'd1;
                        if (r_widx == 2'd3) begin
                            f_valid = 1'b1;
                            f = make_field((r_phase == PH_REV) ? FC_REVISION :
                                           (r_phase == PH_DIM) ? FC_DIM : FC_OFF,
                                           8'd0, 5'd0, acc_new);
                            n_wacc  = 32'd0;
                            n_phase = (r_phase == PH_REV) ? PH_FLAGS :
                                      (r_phase == PH_DIM) ? PH_OFF : PH_THRCOUNT;
                        end else begin
                            n_wacc = acc_new;
                        end
                    end
                    PH_FLAGS: begin
                        if ((leaving & FLAGS_RSVD) != 8'd0) begin
                            n_struct_err = 1'b1;
                        end else begin
                            f_valid = 1'b1;
                            f = make_field(FC_FLAGS, 8'd0, 5'd0, {24'd0, leaving});
                            n_phase = PH_ROT;
                        end
                    end
                    PH_ROT: begin
                        f_valid = 1'b1;
                        f = make_field(FC_ROTATION, 8'd0, 5'd0, {24'd0, leaving});
                        n_phase = PH_BRIGHT;
                    end
                    PH_BRIGHT: begin
                        f_valid = 1'b1;
                        f = make_field(FC_BRIGHTNESS, 8'd0, 5'd0, {24'd0, leaving});
                        n_wacc  = 32'd0;
                        n_widx  = 2'd0;
                        n_phase = PH_DIM;
                    end
                    PH_THRCOUNT: begin
                        if (leaving == 8'd0 || {1'b0, leaving} > 9'(MAX_THRESHOLDS)) begin
                            n_struct_err = 1'b1;
                        end else begin
                            f_valid = 1'b1;
                            f = make_field(FC_THR_COUNT, 8'd0, 5'd0, {24'd0, leaving});
                            n_total = leaving;
                            n_index = 8'd0;
                            n_phase = PH_THR;
                        end
                    end
                    PH_THR: begin
                        f_valid = 1'b1;
                        f = make_field(FC_THRESHOLD, r_index, 5'd0, {24'd0, leaving});
                        n_index = idx_inc;
                        if (idx_inc == r_total) n_phase = PH_HIDCOUNT;
                    end
                    PH_HIDCOUNT, PH_ORDCOUNT: begin
                        if ({1'b0, leaving} > 9'(MAX_IDS)) begin
                            n_struct_err = 1'b1;
                        end else begin
                            f_valid = 1'b1;
                            f = make_field(base, 8'd0, 5'd0, {24'd0, leaving});
                            n_total = leaving;
                            n_index = 8'd0;
                            if (leaving == 8'd0) n_phase = after;
                            else n_phase = ord ? PH_ORDLEN : PH_HIDLEN;
                        end
                    end
                    PH_HIDLEN, PH_ORDLEN: begin
                        if (leaving == 8'd0 || {1'b0, leaving} >= 9'(TEXT_BYTES)) begin
                            n_struct_err = 1'b1;
                        end else begin
                            f_valid = 1'b1;
                            f = make_field(base + FC_LEN_OFS, r_index, 5'd0,
                                           {24'd0, leaving});
                            n_chars_left = leaving;
                            n_char_pos   = 5'd0;
                            n_phase      = ord ? PH_ORDCHAR : PH_HIDCHAR;
                        end
                    end
                    PH_HIDCHAR, PH_ORDCHAR: begin
                        f_valid = 1'b1;
                        f = make_field(base + FC_CHAR_OFS, r_index, r_char_pos,
                                       {24'd0, leaving});
                        n_char_pos   = r_char_pos + 5'd1;
                        n_chars_left = cl_dec;
                        if (cl_dec == 8'd0) begin
                            n_index = idx_inc;
                            if (idx_inc == r_total) n_phase = after;
                            else n_phase = ord ? PH_ORDLEN : PH_HIDLEN;
                        end
                    end
                    default: begin
                        // trailing content past the order list
                        n_struct_err = 1'b1;
                    end
                endcase
            end
        end else begin
            n_tail[r_byte_count[1:0]] = i_byte;
        end

        if (r_byte_count != 10'd1023) n_byte_count = r_byte_count + 10'd1;

        stored = {n_tail[3], n_tail[2], n_tail[1], n_tail[0]};
        if (n_byte_count > 10'(MAX_BLOB_BYTES)) begin
            st = ST_TOO_LARGE;
        end else if (n_byte_count < 10'(MIN_BLOB_BYTES) || n_header_bad[0]) begin
            st = ST_MALFORMED;
        end else if (n_header_bad[1]) begin
            st = ST_UNSUPPORTED;
        end else if (~n_crc != stored) begin
            st = ST_BAD_CRC;
        end else if (n_struct_err || n_phase != PH_DONE) begin
            st = ST_MALFORMED;
        end else begin
            st = ST_OK;
        end

        o_push.field_valid  = i_advance && f_valid;
        o_push.status_valid = i_advance && i_last;
        o_push.field        = f;
        o_push.field.run_last = !i_last;
        o_push.stat         = make_field(FC_REVISION, 8'd0, 5'd0, 32'd0);
        o_push.stat.is_status = 1'b1;
        o_push.stat.status    = st;
        o_push.stat.run_last  = 1'b1;

        // end of blob: back to the power-on state
        if (i_last) begin
            for (int k = 0; k < 4; k++) begin
                n_tail[k] = 8'd0;
            end
            n_byte_count = 10'd0;
            n_crc        = CRC_INIT;
            n_header_bad = 2'b00;
            n_phase      = PH_MAGIC0;
            n_wacc       = 32'd0;
            n_widx       = 2'd0;
            n_total      = 8'd0;
            n_index      = 8'd0;
            n_chars_left = 8'd0;
            n_char_pos   = 5'd0;
            n_struct_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_tail[k] <= 8'd0;
            end
            r_byte_count <= 10'd0;
            r_crc        <= CRC_INIT;
            r_header_bad <= 2'b00;
            r_phase      <= PH_MAGIC0;
            r_wacc       <= 32'd0;
            r_widx       <= 2'd0;
            r_total      <= 8'd0;
            r_index      <= 8'd0;
            r_chars_left <= 8'd0;
            r_char_pos   <= 5'd0;
            r_struct_err <= 1'b0;
        end else if (i_advance) begin
            for (int k = 0; k < 4; k++) begin
                r_tail[k] <= n_tail[k];
            end
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_header_bad <= n_header_bad;
            r_phase      <= n_phase;
            r_wacc       <= n_wacc;
            r_widx       <= n_widx;
            r_total      <= n_total;
            r_index      <= n_index;
            r_chars_left <= n_chars_left;
            r_char_pos   <= n_char_pos;
            r_struct_err <= n_struct_err;
        end
    end

`ifndef SYNTHESIS
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_last |=> r_phase == PH_MAGIC0 && r_byte_count == 10'd0
                                && !r_struct_err)
        else $error("parser state not cleared after last beat");
    a_no_field_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.field_valid |-> !r_struct_err)
        else $error("field emitted after structural error");
    a_hold_without_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_phase) && $stable(r_crc) && $stable(r_byte_count))
        else $error("parser state moved without a byte step");
`endif

endmodule

@@ hdl/sbp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sbp_out_fifo
// Small result queue; takes up to two results per cycle, drives one per beat.
// ----------------------------------------------------------------------------
module sbp_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbp_pkg::t_push   i_push,
    output logic             o_room,
    sbp_out_if.source        o_out
);
    import sbp_pkg::*;

    t_result           r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wr, n_wr;
    logic [OQ_AW-1:0]  r_rd, n_rd;
    logic [OQ_CW-1:0]  r_count, n_count;
    logic [OQ_AW-1:0]  wr_second;
    logic              pop;
    logic [OQ_CW-1:0]  n_push;

    assign pop       = o_out.valid && o_out.ready;
    assign n_push    = OQ_CW'(i_push.field_valid) + OQ_CW'(i_push.status_valid);
    assign wr_second = r_wr + OQ_AW'(i_push.field_valid);
    assign n_wr      = r_wr + OQ_AW'(n_push);
    assign n_rd      = r_rd + OQ_AW'(pop);
    assign n_count   = r_count + n_push - OQ_CW'(pop);
    assign o_room    = (r_count <= OQ_CW'(OQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.field_valid) r_mem[r_wr] <= i_push.field;
        if (i_push.status_valid) r_mem[wr_second] <= i_push.stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_out.valid       = (r_count != '0);
    assign o_out.is_status   = r_mem[r_rd].is_status;
    assign o_out.field_code  = r_mem[r_rd].field_code;
    assign o_out.entry_index = r_mem[r_rd].entry_index;
    assign o_out.char_index  = r_mem[r_rd].char_index;
    assign o_out.field_value = r_mem[r_rd].field_value;
    assign o_out.status      = r_mem[r_rd].status;
    assign o_out.run_last    = r_mem[r_rd].run_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CW'(OQ_DEPTH))
        else $error("result queue overflow");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.field_valid || i_push.status_valid) |-> o_room)
        else $error("push without two free slots");
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid)
        else $error("result beat dropped while stalled");
`endif

endmodule

@@ hdl/settings_blob_parser.sv @@
// Path: input stage register, then result queue, then o_out.
// Throughput: one byte per cycle while o_out is drained every cycle; the
//   final byte of a blob can yield two results (field and status), which
//   the 4-entry result queue absorbs, so intake pauses only on back-pressure.
// Reset: synchronous, active low; clears the parser to expect a new blob's
//   magic and empties the input stage and the result queue.
// ----------------------------------------------------------------------------
// settings_blob_parser
// Streaming settings blob decoder: CRC-32 check over the content, header
// check, and decode of every field once its last byte leaves the delay line.
// ----------------------------------------------------------------------------
module settings_blob_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbp_in_if.sink    i_in,
    sbp_out_if.source o_out
);
    import sbp_pkg::*;

    // Input stage: one beat is held here while the core step is evaluated.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       room;
    logic       advance;
    t_push      push;

    // The core consumes the held beat only when the result queue can take
    // both results a final byte may produce.
    assign advance    = r_in_valid && room;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Byte step: tail delay line, CRC, parser phase and status
    sbp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_push    (push)
    );

    // Result queue toward the output channel
    sbp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

@@ bench/sbp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbp_checker
// Watches both channels of the blob parser, predicts every result beat from
// the accepted byte beats and compares them in order, field by field.
// ----------------------------------------------------------------------------
module sbp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbp_in_if          i_in_mon,
    sbp_out_if         i_out_mon,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked,
    output logic [7:0] o_status_seen
);
    import sbp_pkg::*;

    typedef enum logic [4:0] {
        PH_MAGIC_A, PH_MAGIC_M, PH_MAGIC_S, PH_MAGIC_T, PH_VERSION,
        PH_REVISION, PH_FLAGS, PH_ROTATION, PH_BRIGHTNESS, PH_DIM, PH_OFF,
        PH_THR_COUNT, PH_THR, PH_HID_COUNT, PH_HID_LEN, PH_HID_CHAR,
        PH_ORD_COUNT, PH_ORD_LEN, PH_ORD_CHAR, PH_DONE
    } t_parse_phase;

    localparam logic [31:0] MAGIC_SEQ = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

    // decoder state
    logic [7:0]   tail [4];
    logic [9:0]   byte_cnt;
    logic [31:0]  crc;
    logic [1:0]   hdr_bad;     // bit 0 magic, bit 1 version
    t_parse_phase phase;
    logic [31:0]  word;
    logic [1:0]   word_idx;
    logic [7:0]   elem_total;
    logic [7:0]   elem_idx;
    logic [7:0]   chars_left;
    logic [4:0]   char_pos;
    logic         struct_err;

    t_result      expected_q [$];
    t_result      held;
    logic         have_held = 1'b0;
    int           errs      = 0;
    int           checked   = 0;
    logic [7:0]   seen      = '0;

    task automatic clear_decoder();
        for (int i = 0; i < 4; i++) tail[i] = '0;
        byte_cnt   = '0;
        crc        = CRC_INIT;
        hdr_bad    = '0;
        phase      = PH_MAGIC_A;
        word       = '0;
        word_idx   = '0;
        elem_total = '0;
        elem_idx   = '0;
        chars_left = '0;
        char_pos   = '0;
        struct_err = 1'b0;
    endtask

    function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // one beat behind, so the last result of a byte can get run_last
    task automatic queue_result(input t_result r);
        if (have_held) expected_q.push_back(held);
        held      = r;
        have_held = 1'b1;
    endtask

    task automatic emit_field(input logic [3:0] code, input logic [7:0] entry,
                              input logic [4:0] chr, input logic [31:0] value);
        t_result r;
        r             = '0;
        r.field_code  = code;
        r.entry_index = entry[2:0];
        r.char_index  = chr;
        r.field_value = value;
        queue_result(r);
    endtask

    task automatic list_step(input logic [7:0] b, input logic [3:0] base,
                             input t_parse_phase count_ph, input t_parse_phase after);
        int step;
        step = int'(phase) - int'(count_ph);
        if (step == 0) begin
            if (b > MAX_IDS) begin
                struct_err = 1'b1;
                return;
            end
            emit_field(base, 8'd0, 5'd0, {24'd0, b});
            elem_total = b;
            elem_idx   = '0;
            phase      = (b == 0) ? after : t_parse_phase'(int'(count_ph) + 1);
        end else if (step == 1) begin
            if (b == 0 || b >= TEXT_BYTES) begin
                struct_err = 1'b1;
                return;
            end
            emit_field(base + FC_LEN_OFS, elem_idx, 5'd0, {24'd0, b});
            chars_left = b;
            char_pos   = '0;
            phase      = t_parse_phase'(int'(count_ph) + 2);
        end else begin
            emit_field(base + FC_CHAR_OFS, elem_idx, char_pos, {24'd0, b});
            char_pos   = char_pos + 1'b1;
            chars_left = chars_left - 1'b1;
            if (chars_left == 0) begin
                elem_idx = elem_idx + 1'b1;
                phase    = (elem_idx == elem_total) ? after
                                                    : t_parse_phase'(int'(count_ph) + 1);
            end
        end
    endtask

    // a byte leaving the delay line is content
    task automatic content_step(input logic [7:0] b);
        crc = crc_update(crc, b);
        if (struct_err) return;
        case (phase)
            PH_MAGIC_A, PH_MAGIC_M, PH_MAGIC_S, PH_MAGIC_T: begin
                if (b != MAGIC_SEQ[8 * int'(phase) +: 8]) hdr_bad[0] = 1'b1;
                phase = t_parse_phase'(int'(phase) + 1);
            end
            PH_VERSION: begin
                if (hdr_bad == 0 && b != BLOB_VERSION) hdr_bad[1] = 1'b1;
                if (hdr_bad != 0) struct_err = 1'b1;
                word     = '0;
                word_idx = '0;
                phase    = PH_REVISION;
            end
            PH_REVISION, PH_DIM, PH_OFF: begin
                word     = word | ({24'd0, b} << (8 * word_idx));
                word_idx = word_idx + 1'b1;
                if (word_idx == 0) begin
                    case (phase)
                        PH_REVISION: begin
                            emit_field(FC_REVISION, 8'd0, 5'd0, word);
                            phase = PH_FLAGS;
                        end
                        PH_DIM: begin
                            emit_field(FC_DIM, 8'd0, 5'd0, word);
                            phase = PH_OFF;
                        end
                        default: begin
                            emit_field(FC_OFF, 8'd0, 5'd0, word);
                            phase = PH_THR_COUNT;
                        end
                    endcase
                    word = '0;
                end
            end
            PH_FLAGS: begin
                if ((b & FLAGS_RSVD) != 0) begin
                    struct_err = 1'b1;
                end else begin
                    emit_field(FC_FLAGS, 8'd0, 5'd0, {24'd0, b});
                    phase = PH_ROTATION;
                end
            end
            PH_ROTATION: begin
                emit_field(FC_ROTATION, 8'd0, 5'd0, {24'd0, b});
                phase = PH_BRIGHTNESS;
            end
            PH_BRIGHTNESS: begin
                emit_field(FC_BRIGHTNESS, 8'd0, 5'd0, {24'd0, b});
                word     = '0;
                word_idx = '0;
                phase    = PH_DIM;
            end
            PH_THR_COUNT: begin
                if (b == 0 || b > MAX_THRESHOLDS) begin
                    struct_err = 1'b1;
                end else begin
                    emit_field(FC_THR_COUNT, 8'd0, 5'd0, {24'd0, b});
                    elem_total = b;
                    elem_idx   = '0;
                    phase      = PH_THR;
                end
            end
            PH_THR: begin
                emit_field(FC_THRESHOLD, elem_idx, 5'd0, {24'd0, b});
                elem_idx = elem_idx + 1'b1;
                if (elem_idx == elem_total) phase = PH_HID_COUNT;
            end
            PH_HID_COUNT, PH_HID_LEN, PH_HID_CHAR:
                list_step(b, FC_HID_COUNT, PH_HID_COUNT, PH_ORD_COUNT);
            PH_ORD_COUNT, PH_ORD_LEN, PH_ORD_CHAR:
                list_step(b, FC_ORD_COUNT, PH_ORD_COUNT, PH_DONE);
            default:
                struct_err = 1'b1;   // content past the order list
        endcase
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [7:0]  leaving;
        logic [31:0] stored;
        logic [2:0]  st;
        t_result     r;
        if (byte_cnt >= 4) begin
            leaving = tail[0];
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = tail[3];
            tail[3] = b;
            content_step(leaving);
        end else begin
            tail[byte_cnt[1:0]] = b;
        end
        if (byte_cnt != 10'h3FF) byte_cnt = byte_cnt + 1'b1;

        if (last) begin
            stored = {tail[3], tail[2], tail[1], tail[0]};
            if (byte_cnt > MAX_BLOB_BYTES)                         st = ST_TOO_LARGE;
            else if (byte_cnt < MIN_BLOB_BYTES || hdr_bad[0])      st = ST_MALFORMED;
            else if (hdr_bad[1])                                   st = ST_UNSUPPORTED;
            else if (~crc != stored)                               st = ST_BAD_CRC;
            else if (struct_err || phase != PH_DONE)               st = ST_MALFORMED;
            else                                                   st = ST_OK;
            r           = '0;
            r.is_status = 1'b1;
            r.status    = st;
            queue_result(r);
            seen[st] = 1'b1;
            clear_decoder();
        end

        if (have_held) begin
            held.run_last = 1'b1;
            expected_q.push_back(held);
            have_held = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout int bad);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            bad++;
        end
    endtask

    task automatic check_result();
        t_result exp;
        int      bad;
        bad = 0;
        if (expected_q.size() == 0) begin
            $error("result beat with nothing expected (is_status %0b, field_code %0d)",
                   i_out_mon.is_status, i_out_mon.field_code);
            errs++;
            return;
        end
        exp = expected_q.pop_front();
        check_field("is_status",   32'(exp.is_status),   32'(i_out_mon.is_status),   bad);
        check_field("field_code",  32'(exp.field_code),  32'(i_out_mon.field_code),  bad);
        check_field("entry_index", 32'(exp.entry_index), 32'(i_out_mon.entry_index), bad);
        check_field("char_index",  32'(exp.char_index),  32'(i_out_mon.char_index),  bad);
        check_field("field_value", exp.field_value,      i_out_mon.field_value,      bad);
        check_field("status",      32'(exp.status),      32'(i_out_mon.status),      bad);
        check_field("run_last",    32'(exp.run_last),    32'(i_out_mon.run_last),    bad);
        if (bad != 0) errs++;
        checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            expected_q.delete();
            have_held = 1'b0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                predict_byte(i_in_mon.data_byte, i_in_mon.last_byte);
            if (i_out_mon.valid && i_out_mon.ready)
                check_result();
        end
        o_errors      <= errs;
        o_pending     <= expected_q.size();
        o_checked     <= checked;
        o_status_seen <= seen;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the settings blob parser. Whole blobs are built
// here (well formed with random content, or carrying one chosen defect) and
// streamed a byte per beat; sbp_checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
    import sbp_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    // Far above the longest legal gap (random idles, drain pauses, parser latency).
    localparam int STALL_LIMIT = 4000;
    // Random part runs one blob per idling mix at least, and stops once
    // this many bytes went in.
    localparam int RANDOM_BYTES = 200;

    // What a blob gets wrong, if anything.
    typedef enum {
        DF_NONE,
        DF_BAD_MAGIC,      // one magic byte altered
        DF_BAD_VERSION,    // version other than 1
        DF_BAD_HEADER,     // magic and version both wrong
        DF_BAD_FLAGS,      // a reserved flag bit set
        DF_THR_ZERO,       // threshold count of zero
        DF_THR_MANY,       // threshold count above the maximum
        DF_IDS_MANY,       // identifier count above the maximum
        DF_LEN_ZERO,       // empty identifier
        DF_LEN_LONG,       // identifier length at or above the text size
        DF_EXTRA,          // content after the order list (or padded to a size)
        DF_TRUNCATED,      // content ends inside the structure
        DF_SHORT,          // blob cut to a given length below the minimum
        DF_NOISE           // random bytes
    } t_defect;

    // How large the lists get.
    typedef enum { SH_MIN, SH_RANDOM, SH_MAX } t_shape;

    logic       clk;
    logic       rst_n;
    int         idle_pct  = 0;   // sender: chance of an idle cycle before a beat
    int         stall_pct = 0;   // receiver: chance of ready low in a cycle
    int         err_count;
    int         pending;
    int         checked;
    logic [7:0] status_seen;
    int         bytes_sent = 0;
    int         blobs_sent = 0;
    int         idle_cycles = 0;
    logic [7:0] blob_q [$];

    sbp_in_if  in_ch ();
    sbp_out_if out_ch ();

    settings_blob_parser u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sbp_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_errors      (err_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure: ready drops at random at the current stall rate.
    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hang detection: count cycles where neither channel moves a beat.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // One byte beat: optional idle cycles first, then hold valid until taken.
    // valid stays high afterwards so back-to-back beats need no extra edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // Stop sending until every predicted result has been drained.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Build one blob into blob_q and stream it.
    // target: for DF_SHORT the cut length, for DF_NOISE the length, for
    // DF_EXTRA the total size to pad to (0 = a few extra bytes).
    task automatic send_blob(input t_defect df, input t_shape sh, input int target,
                             input bit bad_crc);
        logic [7:0]  v;
        logic [31:0] crc;
        int          thr_n;
        int          n_ids;
        int          len;
        int          pad;
        int          bad_list;
        int          k;
        blob_q.delete();
        bad_list = $urandom_range(0, 1);

        if (df == DF_NOISE) begin
            for (int i = 0; i < target; i++) blob_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            // header: magic, version
            blob_q.push_back(MAGIC_0);
            blob_q.push_back(MAGIC_1);
            blob_q.push_back(MAGIC_2);
            blob_q.push_back(MAGIC_3);
            if (df == DF_BAD_MAGIC || df == DF_BAD_HEADER) begin
                k = $urandom_range(0, 3);
                blob_q[k] = blob_q[k] ^ 8'($urandom_range(1, 255));
            end
            v = BLOB_VERSION;
            if (df == DF_BAD_VERSION || df == DF_BAD_HEADER) begin
                do v = 8'($urandom_range(0, 255)); while (v == BLOB_VERSION);
            end
            blob_q.push_back(v);

            // revision, flags, rotation, brightness, dim, off
            for (int i = 0; i < 4; i++) blob_q.push_back(8'($urandom_range(0, 255)));
            v = 8'($urandom_range(0, 7));
            if (df == DF_BAD_FLAGS) v[$urandom_range(3, 7)] = 1'b1;
            blob_q.push_back(v);
            for (int i = 0; i < 10; i++) blob_q.push_back(8'($urandom_range(0, 255)));

            // thresholds
            thr_n = (sh == SH_MIN) ? 1 :
                    (sh == SH_MAX) ? MAX_THRESHOLDS : $urandom_range(1, MAX_THRESHOLDS);
            v = 8'(thr_n);
            if (df == DF_THR_ZERO) v = 8'd0;
            if (df == DF_THR_MANY) v = 8'($urandom_range(MAX_THRESHOLDS + 1, 255));
            blob_q.push_back(v);
            for (int i = 0; i < thr_n; i++) blob_q.push_back(8'($urandom_range(0, 255)));

            // hidden list, then order list
            for (int lst = 0; lst < 2; lst++) begin
                n_ids = (sh == SH_MIN) ? 0 :
                        (sh == SH_MAX) ? MAX_IDS :
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_IDS)
                                                    : $urandom_range(0, 2);
                if ((df == DF_LEN_ZERO || df == DF_LEN_LONG) && lst == bad_list && n_ids == 0)
                    n_ids = 1;
                v = 8'(n_ids);
                if (df == DF_IDS_MANY && lst == bad_list)
                    v = 8'($urandom_range(MAX_IDS + 1, 255));
                blob_q.push_back(v);
                for (int e = 0; e < n_ids; e++) begin
                    // first id of a max-shape list takes the longest name
                    len = (sh == SH_MAX) ? ((e == 0) ? TEXT_BYTES - 1 : $urandom_range(1, 4)) :
                          (sh == SH_MIN) ? 1 :
                          ($urandom_range(0, 7) == 0) ? $urandom_range(1, TEXT_BYTES - 1)
                                                      : $urandom_range(1, 5);
                    v = 8'(len);
                    if (lst == bad_list && e == 0) begin
                        if (df == DF_LEN_ZERO) v = 8'd0;
                        if (df == DF_LEN_LONG) v = 8'($urandom_range(TEXT_BYTES, 255));
                    end
                    blob_q.push_back(v);
                    for (int c = 0; c < len; c++) blob_q.push_back(8'($urandom_range(0, 255)));
                end
            end

            if (df == DF_EXTRA) begin
                pad = (target > 0) ? target - blob_q.size() - 4 : $urandom_range(1, 3);
                for (int i = 0; i < pad; i++) blob_q.push_back(8'($urandom_range(0, 255)));
            end
            if (df == DF_TRUNCATED) begin
                k = $urandom_range(1, 4);
                repeat (k) void'(blob_q.pop_back());
            end

            // trailing CRC-32, little-endian
            crc = CRC_INIT;
            foreach (blob_q[i]) crc = crc32_byte(crc, blob_q[i]);
            crc = ~crc;
            if (bad_crc) begin
                k = $urandom_range(0, 31);
                crc[k] = ~crc[k];
            end
            blob_q.push_back(crc[7:0]);
            blob_q.push_back(crc[15:8]);
            blob_q.push_back(crc[23:16]);
            blob_q.push_back(crc[31:24]);

            if (df == DF_SHORT) begin
                while (blob_q.size() > target) void'(blob_q.pop_back());
            end
        end

        foreach (blob_q[i]) send_byte(blob_q[i], i == blob_q.size() - 1);
        blobs_sent++;
    endtask

    initial begin
        int      start_bytes;
        int      rnd_blob;
        int      idle_phase;
        t_defect df;
        int      target;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.last_byte <= 1'b0;
        rst_n           <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed blobs, no idling ----
        // short blobs: up to four bytes nothing is hashed; up to 27 is too short
        send_blob(DF_SHORT, SH_MIN, 1, 1'b0);
        send_blob(DF_SHORT, SH_MIN, 3, 1'b0);
        send_blob(DF_SHORT, SH_MIN, 4, 1'b0);
        send_blob(DF_SHORT, SH_MIN, MIN_BLOB_BYTES - 1, 1'b0);
        // smallest and largest well-formed layouts
        send_blob(DF_NONE, SH_MIN, 0, 1'b0);
        send_blob(DF_NONE, SH_MAX, 0, 1'b0);
        // header failures and status priority
        send_blob(DF_BAD_MAGIC,   SH_MIN, 0, 1'b0);
        send_blob(DF_BAD_VERSION, SH_MIN, 0, 1'b0);
        send_blob(DF_BAD_HEADER,  SH_MIN, 0, 1'b0);
        send_blob(DF_NONE,        SH_MIN, 0, 1'b1);
        send_blob(DF_BAD_VERSION, SH_MIN, 0, 1'b1);   // version beats checksum
        send_blob(DF_BAD_FLAGS,   SH_MIN, 0, 1'b1);   // checksum beats structure
        // structural errors
        send_blob(DF_BAD_FLAGS, SH_MIN, 0, 1'b0);
        send_blob(DF_THR_ZERO,  SH_MIN, 0, 1'b0);
        send_blob(DF_THR_MANY,  SH_MIN, 0, 1'b0);
        send_blob(DF_IDS_MANY,  SH_MIN, 0, 1'b0);
        send_blob(DF_LEN_ZERO,  SH_MIN, 0, 1'b0);
        send_blob(DF_LEN_LONG,  SH_MIN, 0, 1'b0);
        send_blob(DF_EXTRA,     SH_MIN, 0, 1'b0);
        send_blob(DF_TRUNCATED, SH_MIN, 0, 1'b0);
        // size limit: one byte over the maximum is too large
        send_blob(DF_EXTRA, SH_MIN, MAX_BLOB_BYTES + 1, 1'b0);
        send_blob(DF_NOISE, SH_MIN, 17, 1'b0);
        drain();

        // ---- Random blobs across the idling phases ----
        // Each blob runs under the next idling mix; before each change the
        // sender waits for the results to drain.
        start_bytes = bytes_sent;
        rnd_blob    = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES || rnd_blob < 4) begin
            drain();
            idle_phase = rnd_blob % 4;
            case (idle_phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 54; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            // mostly well-formed blobs with random content
            if ($urandom_range(0, 99) < 60) df = DF_NONE;
            else                            df = t_defect'($urandom_range(1, DF_NOISE));
            target = (df == DF_SHORT) ? $urandom_range(1, MIN_BLOB_BYTES - 1) :
                     (df == DF_NOISE) ? $urandom_range(1, 40) : 0;
            send_blob(df, SH_RANDOM, target, $urandom_range(0, 9) == 0);
            rnd_blob++;
        end

        // ---- Wind down ----
        idle_pct  = 0;
        stall_pct = 0;
        drain();
        repeat (8) @(posedge clk);

        $display("Run: %0d blobs, %0d byte beats in, %0d result beats checked",
                 blobs_sent, bytes_sent, checked);
        $display("Final status codes reached (bit per code): %b, idling phases: 4",
                 status_seen);
        if (err_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sbp_pkg.sv
hdl/sbp_in_if.sv
hdl/sbp_out_if.sv
hdl/sbp_core.sv
hdl/sbp_out_fifo.sv
hdl/settings_blob_parser.sv
bench/sbp_checker.sv
bench/tb_top.sv
